>>> hw/rtl/sync_length_frame_deframer_top_defines.svh
// Assertion macros used by the deframer RTL.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SLFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SLFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/slfd_pkg.sv
`timescale 1ns / 1ps

package slfd_pkg;

  localparam logic [7:0]  SyncFirst         = 8'hB5;
  localparam logic [7:0]  SyncSecond        = 8'h62;
  localparam logic [15:0] MaxPayloadDefault = 16'd512;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_ACTIVE = 3'd1,
    ST_GOOD   = 3'd2,
    ST_CKERR  = 3'd3,
    ST_LENERR = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] payload_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
  } result_t;

endpackage

>>> hw/rtl/slfd_parser.sv
`timescale 1ns / 1ps

module slfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic [15:0]      max_payload_i,
  output slfd_pkg::result_t result_o
);

  slfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  ck_a_q, ck_a_d;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign add_a     = sum_a_q + byte_i;
  assign add_b     = sum_b_q + add_a;
  assign len_full  = {byte_i, len_q[7:0]};
  assign count_inc = count_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= slfd_pkg::PH_SYNC1;
      sum_a_q <= '0;
      sum_b_q <= '0;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      count_q <= '0;
      ck_a_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      count_q <= count_d;
      ck_a_q  <= ck_a_d;
    end
  end

  always_comb begin
    slfd_pkg::status_e status;
    logic              pvalid;
    logic [7:0]        pbyte;
    logic [15:0]       pindex;

    phase_d = phase_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    count_d = count_q;
    ck_a_d  = ck_a_q;
    status  = slfd_pkg::ST_ACTIVE;
    pvalid  = 1'b0;
    pbyte   = '0;
    pindex  = '0;

    unique case (phase_q)
      slfd_pkg::PH_SYNC2: begin
        if (byte_i == slfd_pkg::SyncSecond) begin
          phase_d = slfd_pkg::PH_CLASS;
          sum_a_d = '0;
          sum_b_d = '0;
          class_d = '0;
          id_d    = '0;
          len_d   = '0;
          count_d = '0;
        end else if (byte_i == slfd_pkg::SyncFirst) begin
          phase_d = slfd_pkg::PH_SYNC2;
        end else begin
          phase_d = slfd_pkg::PH_SYNC1;
          status  = slfd_pkg::ST_HUNT;
        end
      end
      slfd_pkg::PH_CLASS: begin
        class_d = byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = slfd_pkg::PH_ID;
      end
      slfd_pkg::PH_ID: begin
        id_d    = byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = slfd_pkg::PH_LEN_LO;
      end
      slfd_pkg::PH_LEN_LO: begin
        len_d   = {8'h00, byte_i};
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = slfd_pkg::PH_LEN_HI;
      end
      slfd_pkg::PH_LEN_HI: begin
        len_d   = len_full;
        sum_a_d = add_a;
        sum_b_d = add_b;
        count_d = '0;
        if (len_full > max_payload_i) begin
          status  = slfd_pkg::ST_LENERR;
          phase_d = slfd_pkg::PH_SYNC1;
        end else if (len_full == 16'd0) begin
          phase_d = slfd_pkg::PH_CK_A;
        end else begin
          phase_d = slfd_pkg::PH_PAYLOAD;
        end
      end
      slfd_pkg::PH_PAYLOAD: begin
        pvalid  = 1'b1;
        pbyte   = byte_i;
        pindex  = count_q;
        sum_a_d = add_a;
        sum_b_d = add_b;
        count_d = count_inc;
        if (count_inc >= len_q) begin
          phase_d = slfd_pkg::PH_CK_A;
        end
      end
      slfd_pkg::PH_CK_A: begin
        ck_a_d  = byte_i;
        phase_d = slfd_pkg::PH_CK_B;
      end
      slfd_pkg::PH_CK_B: begin
        status  = (ck_a_q == sum_a_q && byte_i == sum_b_q) ? slfd_pkg::ST_GOOD
                                                             : slfd_pkg::ST_CKERR;
        phase_d = slfd_pkg::PH_SYNC1;
      end
      default: begin
        // Hunting, and any phase code that cannot occur after reset.
        if (byte_i == slfd_pkg::SyncFirst) begin
          phase_d = slfd_pkg::PH_SYNC2;
        end else begin
          phase_d = slfd_pkg::PH_SYNC1;
          status  = slfd_pkg::ST_HUNT;
        end
      end
    endcase

    result_o.status         = status;
    result_o.payload_byte   = pbyte;
    result_o.payload_valid  = pvalid;
    result_o.payload_index  = pindex;
    result_o.msg_class      = class_d;
    result_o.msg_id         = id_d;
    result_o.payload_length = len_d;
  end

endmodule

>>> hw/rtl/sync_length_frame_deframer_top.sv
`timescale 1ns / 1ps
`include "sync_length_frame_deframer_top_defines.svh"

// Frame deframer for sync/length framed byte streams with an 8-bit Fletcher check.
// Each received word is one byte and gives exactly one result word carrying a status
// (hunting, active, frame good, checksum error, length over limit), the payload byte
// with its index when the byte belongs to the payload, and the class, id and length
// of the current frame. The block takes one word per clock cycle sustained while results
// are taken with out_ready_i; a word moves from the input register through the parser
// into the result register, and the result is held there until it is taken.
// The parser steps its state once per word, which sets that pace.
// The input register lets a new word be accepted while a result waits.
// The length limit resets to 512 and is written through cfg_we_i; the user must write it
// only while the block is idle, as the block itself does not enforce this.

module sync_length_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] payload_length_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0]       max_payload_q;
  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              out_valid_q;
  slfd_pkg::result_t res_d, res_q;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= slfd_pkg::MaxPayloadDefault;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  slfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (byte_q),
    .max_payload_i (max_payload_q),
    .result_o      (res_d)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_valid_o  = res_q.payload_valid;
  assign payload_index_o  = res_q.payload_index;
  assign msg_class_o      = res_q.msg_class;
  assign msg_id_o         = res_q.msg_id;
  assign payload_length_o = res_q.payload_length;

  `SLFD_ASSERT_NXT(a_in_captured, in_valid_i && in_ready_o, in_valid_q,
                   "Accepted word was not held in the input register.")
  `SLFD_ASSERT_NXT(a_in_held, in_valid_q && !advance, in_valid_q && $stable(byte_q),
                   "Stalled input word was lost or changed.")
  `SLFD_ASSERT_IMP(a_payload_active, out_valid_o && payload_valid_o,
                   res_q.status == slfd_pkg::ST_ACTIVE,
                   "Payload word carries a final status.")
  `SLFD_ASSERT_IMP(a_index_in_range, out_valid_o && payload_valid_o,
                   payload_index_o < payload_length_o,
                   "Payload index is beyond the frame length.")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  payload_byte_o;
  logic        payload_valid_o;
  logic [15:0] payload_index_o;
  logic [7:0]  msg_class_o;
  logic [7:0]  msg_id_o;
  logic [15:0] payload_length_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;

  sync_length_frame_deframer_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .payload_byte_o   (payload_byte_o),
    .payload_valid_o  (payload_valid_o),
    .payload_index_o  (payload_index_o),
    .msg_class_o      (msg_class_o),
    .msg_id_o         (msg_id_o),
    .payload_length_o (payload_length_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]        rx_stream_q[$];
  slfd_pkg::result_t deframed_q[$];
  int         pushed_cnt = 0;
  int         taken_cnt = 0;
  int         err_cnt = 0;
  int unsigned cyc_cnt = 0;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;

  slfd_pkg::phase_e rx_phase = slfd_pkg::PH_SYNC1;
  logic [7:0]  fl_a = 8'h00;
  logic [7:0]  fl_b = 8'h00;
  logic [7:0]  cur_class = 8'h00;
  logic [7:0]  cur_id = 8'h00;
  logic [15:0] cur_len = 16'h0000;
  logic [15:0] pay_cnt = 16'h0000;
  logic [7:0]  ck_a_seen = 8'h00;
  logic [15:0] limit_model = slfd_pkg::MaxPayloadDefault;

  logic [7:0]  gen_a;
  logic [7:0]  gen_b;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic slfd_pkg::status_e hunt_step(input logic [7:0] b);
    if (b == slfd_pkg::SyncFirst) begin
      rx_phase = slfd_pkg::PH_SYNC2;
      return slfd_pkg::ST_ACTIVE;
    end
    rx_phase = slfd_pkg::PH_SYNC1;
    return slfd_pkg::ST_HUNT;
  endfunction

  function automatic void fletcher_acc(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endfunction

  function automatic slfd_pkg::result_t deframe_word(input logic [7:0] b);
    slfd_pkg::result_t r;
    r = '0;
    r.status = slfd_pkg::ST_ACTIVE;
    case (rx_phase)
      slfd_pkg::PH_SYNC2: begin
        if (b == slfd_pkg::SyncSecond) begin
          rx_phase = slfd_pkg::PH_CLASS;
          fl_a = 8'h00;
          fl_b = 8'h00;
          cur_class = 8'h00;
          cur_id = 8'h00;
          cur_len = 16'h0000;
          pay_cnt = 16'h0000;
        end else begin
          r.status = hunt_step(b);
        end
      end
      slfd_pkg::PH_CLASS: begin
        cur_class = b;
        fletcher_acc(b);
        rx_phase = slfd_pkg::PH_ID;
      end
      slfd_pkg::PH_ID: begin
        cur_id = b;
        fletcher_acc(b);
        rx_phase = slfd_pkg::PH_LEN_LO;
      end
      slfd_pkg::PH_LEN_LO: begin
        cur_len = {8'h00, b};
        fletcher_acc(b);
        rx_phase = slfd_pkg::PH_LEN_HI;
      end
      slfd_pkg::PH_LEN_HI: begin
        cur_len = {b, cur_len[7:0]};
        fletcher_acc(b);
        pay_cnt = 16'h0000;
        if (cur_len > limit_model) begin
          r.status = slfd_pkg::ST_LENERR;
          rx_phase = slfd_pkg::PH_SYNC1;
        end else if (cur_len == 16'h0000) begin
          rx_phase = slfd_pkg::PH_CK_A;
        end else begin
          rx_phase = slfd_pkg::PH_PAYLOAD;
        end
      end
      slfd_pkg::PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.payload_index = pay_cnt;
        fletcher_acc(b);
        pay_cnt = pay_cnt + 16'd1;
        if (pay_cnt >= cur_len) rx_phase = slfd_pkg::PH_CK_A;
      end
      slfd_pkg::PH_CK_A: begin
        ck_a_seen = b;
        rx_phase = slfd_pkg::PH_CK_B;
      end
      slfd_pkg::PH_CK_B: begin
        r.status = (ck_a_seen == fl_a && b == fl_b) ? slfd_pkg::ST_GOOD
                                                    : slfd_pkg::ST_CKERR;
        rx_phase = slfd_pkg::PH_SYNC1;
      end
      default: begin
        r.status = hunt_step(b);
      end
    endcase
    r.msg_class = cur_class;
    r.msg_id = cur_id;
    r.payload_length = cur_len;
    return r;
  endfunction

  task automatic push_word(input logic [7:0] b);
    rx_stream_q.push_back(b);
    pushed_cnt++;
  endtask

  task automatic push_summed(input logic [7:0] b);
    gen_a = gen_a + b;
    gen_b = gen_b + gen_a;
    push_word(b);
  endtask

  task automatic add_header(input logic [7:0] cls, input logic [7:0] id, input int len);
    logic [15:0] l16;
    l16 = 16'(len);
    gen_a = 8'h00;
    gen_b = 8'h00;
    push_word(slfd_pkg::SyncFirst);
    push_word(slfd_pkg::SyncSecond);
    push_summed(cls);
    push_summed(id);
    push_summed(l16[7:0]);
    push_summed(l16[15:8]);
  endtask

  task automatic add_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                           input bit bad);
    logic [7:0] pb;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    int i;
    add_header(cls, id, len);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        pb = $urandom_range(0, 1) ? slfd_pkg::SyncFirst : slfd_pkg::SyncSecond;
      end else begin
        pb = 8'($urandom_range(0, 255));
      end
      push_summed(pb);
    end
    ck_a = gen_a;
    ck_b = gen_b;
    if (bad) begin
      case ($urandom_range(0, 2))
        0: ck_a = ck_a ^ 8'($urandom_range(1, 255));
        1: ck_b = ck_b ^ 8'($urandom_range(1, 255));
        default: begin
          ck_a = ck_a ^ 8'($urandom_range(1, 255));
          ck_b = ck_b ^ 8'($urandom_range(1, 255));
        end
      endcase
    end
    push_word(ck_a);
    push_word(ck_b);
  endtask

  function automatic int pick_len();
    int m;
    int s;
    int cap;
    m = int'(limit_model);
    s = int'($urandom_range(0, 9));
    if (s < 6) cap = 8;
    else if (s < 9) cap = 40;
    else cap = 300;
    if (cap > m) cap = m;
    if (s == 9 && $urandom_range(0, 1) == 1) return cap;
    return int'($urandom_range(0, cap));
  endfunction

  task automatic gen_traffic(input int budget);
    int start;
    int pick;
    int n;
    int i;
    int lim;
    logic [7:0] b;
    start = pushed_cnt;
    lim = int'(limit_model);
    while (pushed_cnt - start < budget) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 65 || (pick < 75 && lim == 65535)) begin
        add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_len(),
                  $urandom_range(0, 4) == 0);
      end else if (pick < 75) begin
        add_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   int'($urandom_range(lim + 1, 65535)));
      end else if (pick < 90) begin
        n = int'($urandom_range(1, 6));
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 1) == 1) b = slfd_pkg::SyncFirst;
          else b = 8'($urandom_range(0, 255));
          push_word(b);
        end
      end else begin
        push_word(slfd_pkg::SyncFirst);
        b = 8'($urandom_range(0, 255));
        if (b == slfd_pkg::SyncSecond) b = 8'h00;
        if ($urandom_range(0, 2) == 0) b = slfd_pkg::SyncFirst;
        push_word(b);
      end
    end
  endtask

  task automatic wait_drained();
    while (!(taken_cnt == pushed_cnt && deframed_q.size() == 0)) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_model = v;
  endtask

  // Driver: one word per accepted handshake, random gaps between words while idle_on is set.
  always @(posedge clk_i or negedge rst_ni) begin : drv
    int gap_left;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i <= 8'h00;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        deframed_q.push_back(deframe_word(rx_byte_i));
        taken_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rx_stream_q.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
          gap_left = int'($urandom_range(1, 10)) - 1;
          in_valid_i <= 1'b0;
        end else if (rx_stream_q.size() > 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= rx_stream_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : mon
    slfd_pkg::result_t w;
    int stall_left;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (deframed_q.size() == 0) begin
          flag_error("result word with no prediction waiting");
        end else begin
          w = deframed_q.pop_front();
          if (status_o !== w.status)
            flag_error($sformatf("status got %0d want %0d", status_o, w.status));
          if (payload_byte_o !== w.payload_byte)
            flag_error($sformatf("payload_byte got %0h want %0h", payload_byte_o,
                                 w.payload_byte));
          if (payload_valid_o !== w.payload_valid)
            flag_error($sformatf("payload_valid got %0b want %0b", payload_valid_o,
                                 w.payload_valid));
          if (payload_index_o !== w.payload_index)
            flag_error($sformatf("payload_index got %0d want %0d", payload_index_o,
                                 w.payload_index));
          if (msg_class_o !== w.msg_class)
            flag_error($sformatf("msg_class got %0h want %0h", msg_class_o, w.msg_class));
          if (msg_id_o !== w.msg_id)
            flag_error($sformatf("msg_id got %0h want %0h", msg_id_o, w.msg_id));
          if (payload_length_o !== w.payload_length)
            flag_error($sformatf("payload_length got %0d want %0d", payload_length_o,
                                 w.payload_length));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 300;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = int'($urandom_range(1, 10)) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_word(8'h00);
    push_word(8'hFF);
    push_word(slfd_pkg::SyncFirst);
    push_word(8'h00);
    push_word(slfd_pkg::SyncFirst);
    add_frame(8'hFF, 8'h00, 0, 1'b0);
    add_header(8'h00, 8'hFF, int'(slfd_pkg::MaxPayloadDefault) + 1);
    add_frame(8'h01, 8'h80, 2, 1'b1);
    wait_drained();
    gen_traffic(160);

    write_limit(16'h0000);
    gen_traffic(100);

    write_limit(16'hFFFF);
    hold_req = 1'b1;
    gen_traffic(160);

    write_limit(16'd5);
    gen_traffic(120);

    write_limit(16'($urandom_range(6, 80)));
    gen_traffic(80);

    write_limit(slfd_pkg::MaxPayloadDefault);
    idle_on = 1'b0;
    gen_traffic(80);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/slfd_pkg.sv
hw/rtl/slfd_parser.sv
hw/rtl/sync_length_frame_deframer_top.sv
tb/tb_top.sv
